>>> rtl/core/cos_pkg.sv
// ============================================================================
// cos_pkg: shared types and constants for the cosine similarity block
// Holds the state encodings, the status codes and the control structs that
// pass between the top level and the iterative root/divide engine.
// ============================================================================
package cos_pkg;

    // Result magnitude is searched one bit at a time over this many bits.
    localparam int Q_BITS = 16;
    localparam int K_W = 4;
    // The squared Q1.15 scale: q^2 * P is compared against d^2 * 2^SCALE_SH.
    localparam int SCALE_SH = 2 * (Q_BITS - 1);

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ZERO_NORM = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

    typedef enum logic [1:0] {
        T_IDLE,
        T_FLUSH,
        T_EVAL,
        T_ROOT
    } top_state_t;

    typedef enum logic [2:0] {
        R_IDLE,
        R_MUL_D,
        R_MUL_N,
        R_ADD_U,
        R_ADD_A,
        R_CMP,
        R_STEP,
        R_DONE
    } root_state_t;

    typedef struct packed {
        logic start;
        logic ack;
    } root_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } root_sts_t;

endpackage

>>> rtl/core/cos_accum.sv
// ============================================================================
// cos_accum: dot product and squared norm accumulators
// Registers the three element products of each item and adds them into the
// running sums in the next cycle. Counts items and flags a vector that is too long.
// ============================================================================
module cos_accum #(
    parameter int ELEM_BITS = 16,
    parameter int MAX_LEN   = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic [15:0]            a_elem,
    input  logic [15:0]            b_elem,
    input  logic                   clear,
    output logic signed [2*ELEM_BITS-2+$clog2(MAX_LEN+1):0] dot_sum,
    output logic [2*ELEM_BITS-3+$clog2(MAX_LEN+1):0]        norm_a_sum,
    output logic [2*ELEM_BITS-3+$clog2(MAX_LEN+1):0]        norm_b_sum,
    output logic                   too_long
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int NORM_W = 2 * ELEM_BITS - 2 + CNT_W;
    localparam int DOT_W  = NORM_W + 1;
    localparam int PROD_W = 2 * ELEM_BITS;
    localparam int TAKE_W = (ELEM_BITS < 16) ? ELEM_BITS : 16;

    logic [ELEM_BITS-1:0]     a_raw;
    logic [ELEM_BITS-1:0]     b_raw;
    logic signed [PROD_W-1:0] ab_prod;
    logic signed [PROD_W-1:0] aa_prod;
    logic signed [PROD_W-1:0] bb_prod;
    logic                     full;

    logic signed [PROD_W-1:0] ab_reg;
    logic [PROD_W-2:0]        aa_reg;
    logic [PROD_W-2:0]        bb_reg;
    logic                     prod_valid_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     too_long_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    logic [NORM_W-1:0]        na_reg;
    logic [NORM_W-1:0]        nb_reg;

    // The low ELEM_BITS bits of each field form a two's complement element.
    assign a_raw   = ELEM_BITS'(a_elem[TAKE_W-1:0]);
    assign b_raw   = ELEM_BITS'(b_elem[TAKE_W-1:0]);
    assign ab_prod = PROD_W'($signed(a_raw) * $signed(b_raw));
    assign aa_prod = PROD_W'($signed(a_raw) * $signed(a_raw));
    assign bb_prod = PROD_W'($signed(b_raw) * $signed(b_raw));
    assign full    = (count_reg >= CNT_W'(MAX_LEN));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ab_reg <= ab_prod;
            aa_reg <= aa_prod[PROD_W-2:0];
            bb_reg <= bb_prod[PROD_W-2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            count_reg      <= '0;
            too_long_reg   <= 1'b0;
            dot_reg        <= '0;
            na_reg         <= '0;
            nb_reg         <= '0;
        end
        else if (clear)
        begin
            prod_valid_reg <= 1'b0;
            count_reg      <= '0;
            too_long_reg   <= 1'b0;
            dot_reg        <= '0;
            na_reg         <= '0;
            nb_reg         <= '0;
        end
        else
        begin
            prod_valid_reg <= take && !full;
            if (take)
            begin
                if (full)
                begin
                    too_long_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (prod_valid_reg)
            begin
                dot_reg <= dot_reg + DOT_W'(ab_reg);
                na_reg  <= na_reg + NORM_W'(aa_reg);
                nb_reg  <= nb_reg + NORM_W'(bb_reg);
            end
        end
    end

    assign dot_sum    = dot_reg;
    assign norm_a_sum = na_reg;
    assign norm_b_sum = nb_reg;
    assign too_long   = too_long_reg;

endmodule

>>> rtl/core/cos_root.sv
// ============================================================================
// cos_root: iterative square root and divide engine
// Forms d^2 and na*nb by shift-and-add, then finds the largest q with
// q^2*na*nb <= d^2*2^30 one bit per pass, all on one shared wide adder.
// ============================================================================
module cos_root #(
    parameter int NORM_W = 43
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cos_pkg::root_ctl_t         ctl,
    input  logic [NORM_W-1:0]          dmag,
    input  logic [NORM_W-1:0]          na,
    input  logic [NORM_W-1:0]          nb,
    output cos_pkg::root_sts_t         sts,
    output logic [cos_pkg::Q_BITS-1:0] q
);

    localparam int AW    = 2 * NORM_W + 34;
    localparam int CNT_W = $clog2(NORM_W);
    localparam int SH    = cos_pkg::SCALE_SH;

    cos_pkg::root_state_t state_reg, state_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [cos_pkg::K_W-1:0]      k_reg, k_next;
    logic                         hit_reg, hit_next;
    logic [AW-1:0]                s_reg, s_next;
    logic [AW-1:0]                u_reg, u_next;
    logic [AW-1:0]                a_reg, a_next;
    logic [AW-1:0]                t_reg, t_next;
    logic [AW-1:0]                r_reg, r_next;
    logic [NORM_W-1:0]            m_reg, m_next;
    logic [cos_pkg::Q_BITS-1:0]   q_reg, q_next;

    // The one shared adder.
    logic [AW-1:0] add_x;
    logic [AW-1:0] add_y;
    logic [AW-1:0] add_sum;

    assign add_sum = add_x + add_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cos_pkg::R_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        u_reg <= u_next;
        a_reg <= a_next;
        t_reg <= t_next;
        r_reg <= r_next;
        m_reg <= m_next;
        q_reg <= q_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        hit_next   = hit_reg;
        s_next     = s_reg;
        u_next     = u_reg;
        a_next     = a_reg;
        t_next     = t_reg;
        r_next     = r_reg;
        m_next     = m_reg;
        q_next     = q_reg;
        add_x      = s_reg;
        add_y      = '0;
        sts.busy   = (state_reg != cos_pkg::R_IDLE);
        sts.done   = 1'b0;

        unique case (state_reg)
            cos_pkg::R_IDLE:
            begin
                if (ctl.start)
                begin
                    s_next     = '0;
                    a_next     = AW'(dmag);
                    m_next     = dmag;
                    cnt_next   = CNT_W'(NORM_W - 1);
                    state_next = cos_pkg::R_MUL_D;
                end
            end

            cos_pkg::R_MUL_D, cos_pkg::R_MUL_N:
            begin
                add_x    = s_reg;
                add_y    = m_reg[0] ? a_reg : '0;
                s_next   = add_sum;
                a_next   = {a_reg[AW-2:0], 1'b0};
                m_next   = {1'b0, m_reg[NORM_W-1:1]};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    cnt_next = CNT_W'(NORM_W - 1);
                    s_next   = '0;
                    if (state_reg == cos_pkg::R_MUL_D)
                    begin
                        // Right-hand side: d^2 scaled by 2^30.
                        r_next     = {add_sum[AW-SH-1:0], {SH{1'b0}}};
                        a_next     = AW'(na);
                        m_next     = nb;
                        state_next = cos_pkg::R_MUL_N;
                    end
                    else
                    begin
                        // A starts as P shifted for the top result bit.
                        a_next     = {add_sum[AW-SH-1:0], {SH{1'b0}}};
                        u_next     = '0;
                        q_next     = '0;
                        k_next     = cos_pkg::K_W'(cos_pkg::Q_BITS - 1);
                        state_next = cos_pkg::R_ADD_U;
                    end
                end
            end

            cos_pkg::R_ADD_U:
            begin
                add_x      = s_reg;
                add_y      = u_reg;
                t_next     = add_sum;
                state_next = cos_pkg::R_ADD_A;
            end

            cos_pkg::R_ADD_A:
            begin
                add_x      = t_reg;
                add_y      = a_reg;
                t_next     = add_sum;
                state_next = cos_pkg::R_CMP;
            end

            cos_pkg::R_CMP:
            begin
                hit_next = (t_reg <= r_reg);
                if (t_reg <= r_reg)
                begin
                    s_next = t_reg;
                    q_next = q_reg | (cos_pkg::Q_BITS'(1) << k_reg);
                end
                state_next = cos_pkg::R_STEP;
            end

            cos_pkg::R_STEP:
            begin
                // U tracks q*P shifted by k+1; A tracks P shifted by 2k.
                add_x  = u_reg;
                add_y  = hit_reg ? {a_reg[AW-2:0], 1'b0} : '0;
                u_next = {1'b0, add_sum[AW-1:1]};
                a_next = {2'b00, a_reg[AW-1:2]};
                if (k_reg == '0)
                begin
                    state_next = cos_pkg::R_DONE;
                end
                else
                begin
                    k_next     = k_reg - cos_pkg::K_W'(1);
                    state_next = cos_pkg::R_ADD_U;
                end
            end

            cos_pkg::R_DONE:
            begin
                sts.done = 1'b1;
                if (ctl.ack)
                begin
                    state_next = cos_pkg::R_IDLE;
                end
            end

            default:
            begin
                state_next = cos_pkg::R_IDLE;
            end
        endcase
    end

    assign q = q_reg;

endmodule

>>> rtl/core/cosine_similarity.sv
// ============================================================================
// cosine_similarity: streaming cosine similarity of two fixed-point vectors
// Accumulates dot product and squared norms, then yields dot/sqrt(na*nb).
// ============================================================================
// Each input item on the s_ channel carries one element pair; s_tlast marks
// the final pair of the two vectors. Ordinary pairs are taken one per cycle.
// The item that carries s_tlast produces one result item on the m_ channel:
// the cosine in signed Q1.15 (truncated toward zero, +1.0 shown as 32767)
// and a status code (ok, zero norm, or length overflow).
// After the last pair the block drops s_tready while the result is formed.
// A zero norm or an overflowed vector gives its result without the root
// engine. Otherwise one shared adder (NORM_W = 43 by default) first does the
// two shift-and-add products, then adds U, adds A, compares and steps for
// each result bit.
// Results sit in an output register; while the receiver stalls the next
// vector may already stream in, and the final step waits for the register.
// Reset clears the sums, the counters, the flags and the output valid.
// ============================================================================
module cosine_similarity #(
    parameter int MAX_LEN   = 4096,
    parameter int ELEM_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // a_elem [15:0], b_elem [31:16]
    input  logic        s_tlast,   // last element pair of the vectors
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // cosine_q15 [15:0], status [17:16], zero fill
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int NORM_W = 2 * ELEM_BITS - 2 + CNT_W;
    localparam int DOT_W  = NORM_W + 1;
    localparam int QB     = cos_pkg::Q_BITS;

    cos_pkg::top_state_t state_reg, state_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [QB-1:0]       cos_reg, cos_next;
    logic [1:0]          status_reg, status_next;

    logic                    take;
    logic                    clear;
    logic                    out_free;
    logic                    out_load;
    logic signed [DOT_W-1:0] dot_sum;
    logic [NORM_W-1:0]       norm_a_sum;
    logic [NORM_W-1:0]       norm_b_sum;
    logic                    too_long;
    logic                    neg;
    logic [DOT_W-1:0]        dot_abs;
    logic [QB-1:0]           root_q;
    logic [QB-1:0]           cos_signed;
    cos_pkg::root_ctl_t      root_ctl;
    cos_pkg::root_sts_t      root_sts;

    assign take     = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    cos_accum #(
        .ELEM_BITS (ELEM_BITS),
        .MAX_LEN   (MAX_LEN)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .a_elem     (s_tdata[15:0]),
        .b_elem     (s_tdata[31:16]),
        .clear      (clear),
        .dot_sum    (dot_sum),
        .norm_a_sum (norm_a_sum),
        .norm_b_sum (norm_b_sum),
        .too_long   (too_long)
    );

    // The sign is applied after the magnitude search.
    assign neg     = dot_sum[DOT_W-1];
    assign dot_abs = neg ? DOT_W'(-dot_sum) : DOT_W'(dot_sum);

    cos_root #(
        .NORM_W (NORM_W)
    ) u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (root_ctl),
        .dmag  (dot_abs[NORM_W-1:0]),
        .na    (norm_a_sum),
        .nb    (norm_b_sum),
        .sts   (root_sts),
        .q     (root_q)
    );

    // A positive magnitude of exactly 1.0 saturates; -1.0 is representable.
    assign cos_signed = neg ? (~root_q + QB'(1))
                            : (root_q[QB-1] ? {1'b0, {(QB-1){1'b1}}} : root_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cos_pkg::T_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cos_reg    <= cos_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cos_next       = cos_reg;
        status_next    = status_reg;
        out_load       = 1'b0;
        clear          = 1'b0;
        root_ctl.start = 1'b0;
        root_ctl.ack   = 1'b0;
        s_tready       = 1'b0;

        unique case (state_reg)
            cos_pkg::T_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && s_tlast)
                begin
                    state_next = cos_pkg::T_FLUSH;
                end
            end

            cos_pkg::T_FLUSH:
            begin
                // The last products enter the sums at the end of this cycle.
                state_next = cos_pkg::T_EVAL;
            end

            cos_pkg::T_EVAL:
            begin
                if (too_long || norm_a_sum == '0 || norm_b_sum == '0)
                begin
                    if (out_free)
                    begin
                        out_load    = 1'b1;
                        clear       = 1'b1;
                        cos_next    = '0;
                        status_next = too_long ? cos_pkg::STATUS_TOO_LONG
                                               : cos_pkg::STATUS_ZERO_NORM;
                        state_next  = cos_pkg::T_IDLE;
                    end
                end
                else
                begin
                    root_ctl.start = 1'b1;
                    state_next     = cos_pkg::T_ROOT;
                end
            end

            cos_pkg::T_ROOT:
            begin
                if (root_sts.done && out_free)
                begin
                    out_load     = 1'b1;
                    clear        = 1'b1;
                    root_ctl.ack = 1'b1;
                    cos_next     = cos_signed;
                    status_next  = cos_pkg::STATUS_OK;
                    state_next   = cos_pkg::T_IDLE;
                end
            end

            default:
            begin
                state_next = cos_pkg::T_IDLE;
            end
        endcase

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, status_reg, cos_reg};

    // The input is closed from the last pair until the result is loaded.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s_tlast) |=> !s_tready)
        else $error("input open after the last pair");

    // A result never overwrites one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten");

    // The root engine is started only when it is idle.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        root_ctl.start |-> !root_sts.busy)
        else $error("root engine started while busy");

    // The engine only finishes while the sequencer waits for it.
    a_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        root_sts.done |-> (state_reg == cos_pkg::T_ROOT))
        else $error("root engine done outside its phase");

    // The sums are cleared only when no pair is being taken.
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clear |-> !take)
        else $error("accumulator cleared during an accepted item");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the streaming cosine similarity block
// Element pairs are streamed in and each vector's result is checked against
// an exact integer model. The run covers extreme values, zero norms, exact
// +1/-1 and orthogonal vectors and random short and medium vectors,
// under several patterns of sender idling and receiver stalls.
// ============================================================================
module tb;

    localparam int VEC_MAX = 4096;   // matches the MAX_LEN default of the block

    // One element pair as it travels on the input channel.
    typedef struct packed {
        logic signed [15:0] b;
        logic signed [15:0] a;
        logic               last;
    } elem_pair_t;

    // One result as it is expected on the output channel.
    typedef struct packed {
        logic [15:0] cosine;
        logic [1:0]  status;
    } cos_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // a_elem [15:0], b_elem [31:16]
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // cosine_q15 [15:0], status [17:16], zero fill

    // Pairs waiting to be driven, and results the model says are due.
    elem_pair_t  pair_queue[$];
    cos_result_t cosine_expected[$];

    // Running sums of the model, mirroring the accumulators of the block.
    longint          sum_dot;
    longint unsigned sum_norm_a;
    longint unsigned sum_norm_b;
    int              pairs_taken;
    bit              overrun;

    // Percentages of idle sender cycles and stalled receiver cycles.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    int errors = 0;
    int vectors_queued = 0;
    int results_ok = 0;
    int results_zero = 0;
    int results_long = 0;

    cosine_similarity u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------------

    // Largest q in [0, 32768] with q^2 * na * nb <= dmag^2 * 2^30, found by a
    // binary search on exact 128-bit products.
    function automatic int cos_root_quotient(longint unsigned dmag,
                                             longint unsigned na,
                                             longint unsigned nb);
        logic [127:0] wide_a;
        logic [127:0] wide_b;
        logic [127:0] wide_d;
        logic [127:0] norm_prod;
        logic [127:0] rhs;
        logic [127:0] lhs;
        logic [127:0] mid_sq;
        int lo;
        int hi;
        int mid;
        wide_a = na;
        wide_b = nb;
        wide_d = dmag;
        norm_prod = wide_a * wide_b;
        rhs = (wide_d * wide_d) << 30;
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            mid_sq = mid * mid;
            lhs = mid_sq * norm_prod;
            if (lhs <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // Takes one accepted pair into the sums; on the last pair it queues the
    // expected result and clears the sums.
    task automatic cos_take_pair(input logic [31:0] data, input logic last);
        longint      a;
        longint      b;
        longint unsigned dmag;
        int          q;
        cos_result_t res;
        a = $signed(data[15:0]);
        b = $signed(data[31:16]);
        // Pairs beyond the length limit are dropped and only flag the vector.
        if (pairs_taken >= VEC_MAX)
        begin
            overrun = 1'b1;
        end
        else
        begin
            sum_dot += a * b;
            sum_norm_a += a * a;
            sum_norm_b += b * b;
            pairs_taken++;
        end
        if (last)
        begin
            res.cosine = '0;
            if (overrun)
            begin
                // An overlong vector wins over a zero norm.
                res.status = cos_pkg::STATUS_TOO_LONG;
            end
            else if (sum_norm_a == 0 || sum_norm_b == 0)
            begin
                res.status = cos_pkg::STATUS_ZERO_NORM;
            end
            else
            begin
                res.status = cos_pkg::STATUS_OK;
                dmag = (sum_dot < 0) ? -sum_dot : sum_dot;
                q = cos_root_quotient(dmag, sum_norm_a, sum_norm_b);
                // -1.0 is representable; +1.0 saturates just below.
                if (sum_dot < 0)
                    res.cosine = 16'(-q);
                else
                    res.cosine = (q > 32767) ? 16'd32767 : 16'(q);
            end
            cosine_expected.insert(cosine_expected.size(), res);
            sum_dot = 0;
            sum_norm_a = 0;
            sum_norm_b = 0;
            pairs_taken = 0;
            overrun = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents queued pairs, holding each one until it is taken.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            sum_dot = 0;
            sum_norm_a = 0;
            sum_norm_b = 0;
            pairs_taken = 0;
            overrun = 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                cos_take_pair(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (pair_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    elem_pair_t p;
                    p = pair_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {p.b, p.a};
                    s_tlast <= p.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (cosine_expected.size() == 0)
                begin
                    $display("%0t: unexpected result, actual cosine %0d status %0d",
                             $time, $signed(m_tdata[15:0]), m_tdata[17:16]);
                    errors++;
                end
                else
                begin
                    cos_result_t res;
                    res = cosine_expected.pop_front();
                    if (m_tdata[15:0] !== res.cosine)
                    begin
                        $display("%0t: cosine mismatch, expected %0d actual %0d",
                                 $time, $signed(res.cosine), $signed(m_tdata[15:0]));
                        errors++;
                    end
                    if (m_tdata[17:16] !== res.status)
                    begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, res.status, m_tdata[17:16]);
                        errors++;
                    end
                    case (res.status)
                        cos_pkg::STATUS_OK:        results_ok++;
                        cos_pkg::STATUS_ZERO_NORM: results_zero++;
                        default:                   results_long++;
                    endcase
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_pair(input int a, input int b, input bit last);
        elem_pair_t p;
        p.a = 16'(a);
        p.b = 16'(b);
        p.last = last;
        pair_queue.insert(pair_queue.size(), p);
    endtask

    // Queues a whole vector of one flavor; returns the number of pairs queued.
    task automatic push_vector(input int flavor, input int len, output int n);
        int a;
        int b;
        int i;
        n = 0;
        for (i = 0; i < len; i++)
        begin
            case (flavor)
                1:
                begin
                    // tiny values make exact cosines and zero dot products common
                    a = int'($urandom_range(8)) - 4;
                    b = int'($urandom_range(8)) - 4;
                end
                2:
                begin
                    a = $urandom;
                    b = a;
                end
                3:
                begin
                    a = $urandom;
                    b = -a;
                end
                4:
                begin
                    a = 0;
                    b = $urandom;
                end
                5:
                begin
                    a = $urandom;
                    b = 0;
                end
                6:
                begin
                    a = int'($urandom_range(2000)) - 1000;
                    b = ($urandom_range(1) != 0) ? 3 * a : -7 * a;
                end
                7:
                begin
                    // a = (x, y), b = (y, -x) keeps the dot product at zero
                    a = int'($urandom_range(20000)) - 10000;
                    b = int'($urandom_range(20000)) - 10000;
                    queue_pair(a, b, 1'b0);
                    n++;
                    i++;
                    { a, b } = { b, -a };
                    if (i >= len)
                        i = len - 1;
                end
                default:
                begin
                    a = $urandom;
                    b = $urandom;
                end
            endcase
            queue_pair(a, b, i == len - 1);
            n++;
        end
        vectors_queued++;
    endtask

    task automatic push_random_vectors(input int target);
        int done;
        int n;
        int len;
        done = 0;
        while (done < target)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
            push_vector($urandom_range(7), len, n);
            done += n;
        end
    endtask

    // Holds the sender off until every queued pair is taken and every
    // expected result has been seen.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pair_queue.size() != 0 || s_tvalid || cosine_expected.size() != 0);
    endtask

    task automatic push_directed();
        // Single pairs at the corners of the element range.
        queue_pair(32767, 32767, 1'b1);
        queue_pair(-32768, -32768, 1'b1);
        queue_pair(-32768, 32767, 1'b1);
        queue_pair(32767, -32768, 1'b1);
        queue_pair(1, -1, 1'b1);
        // Zero norms: first vector, second vector, both.
        queue_pair(0, 5, 1'b1);
        queue_pair(-9, 0, 1'b1);
        queue_pair(0, 0, 1'b1);
        // Orthogonal vectors give zero with status ok.
        queue_pair(3, 4, 1'b0);
        queue_pair(4, -3, 1'b1);
        // 45 degrees apart.
        queue_pair(1, 1, 1'b0);
        queue_pair(0, 1, 1'b1);
        // Alternating bit patterns.
        queue_pair(16'h5555, 16'hAAAA, 1'b0);
        queue_pair(16'hAAAA, 16'h5555, 1'b0);
        queue_pair(16'h00FF, 16'hFF00, 1'b1);
        // Zero pairs ahead of the real data do not disturb the sums.
        queue_pair(0, 0, 1'b0);
        queue_pair(0, 0, 1'b0);
        queue_pair(-1000, 999, 1'b1);
        vectors_queued += 12;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Phase 1: no idling on either side.
        push_directed();
        push_random_vectors(190);
        wait_drained();

        // Phase 2: sender mostly idle.
        send_idle_pct = 88;
        recv_stall_pct = 0;
        push_random_vectors(190);
        wait_drained();

        // Phase 3: receiver mostly stalled, so results back up behind it.
        send_idle_pct = 0;
        recv_stall_pct = 88;
        push_random_vectors(190);
        wait_drained();

        // Phase 4: light idling on both sides.
        send_idle_pct = 22;
        recv_stall_pct = 22;
        push_random_vectors(190);
        wait_drained();

        // Give a stray extra result time to show up.
        repeat (200) @(negedge clk);
        if (cosine_expected.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     cosine_expected.size());
            errors++;
        end

        $display("Streamed %0d vectors, corner ones included, in four",
                 vectors_queued);
        $display("idle patterns: %0d ok, %0d zero-norm, %0d too-long results.",
                 results_ok, results_zero, results_long);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #40_000_000;
        $display("%0t: timeout", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
